@@ sv/cdsem_pkg.sv @@
package cdsem_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int WDAY_W  = 3;
  localparam int PAT_W   = 28;
  localparam int CFG_IDX_W = 4;
  localparam int WSUM_W  = 15;

  localparam int NUM_EVENTS_DEF = 4;

  localparam logic [YEAR_W-1:0]  YEAR_MIN = YEAR_W'(1754);
  localparam logic [YEAR_W-1:0]  YEAR_MAX = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_MAR = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
  localparam logic [5:0]         PAT_DAY_LAST = 6'd63;

  // y / 100 as (y * 5243) >> 19, exact for every 14-bit y
  localparam int DIV100_MUL = 5243;
  localparam int DIV100_SH  = 19;
  localparam int DIV100_PW  = YEAR_W + 13;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               leap;
    logic               rejected;
  } date_rpt_t;

  function automatic logic [7:0] div100(logic [YEAR_W-1:0] y);
    logic [DIV100_PW-1:0] prod;
    prod = DIV100_PW'(y) * DIV100_PW'(DIV100_MUL);
    return prod[DIV100_SH +: 8];
  endfunction

  function automatic logic is_leap(logic [YEAR_W-1:0] y);
    logic [7:0]        q;
    logic [YEAR_W-1:0] r;
    q = div100(y);
    r = y - YEAR_W'(YEAR_W'(q) * YEAR_W'(100));
    // divisible by 4, and either not a century or a century divisible by 400
    return (y[1:0] == 2'b00) && ((r != '0) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11): len = DAY_W'(30);
      MONTH_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
      default: len = DAY_W'(31);
    endcase
    return len;
  endfunction

  // (31 * mm) / 12 with mm the March-based month number
  function automatic logic [DAY_W-1:0] month_offset(logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] off;
    case (m)
      MONTH_W'(1):  off = DAY_W'(28);
      MONTH_W'(2):  off = DAY_W'(31);
      MONTH_W'(3):  off = DAY_W'(2);
      MONTH_W'(4):  off = DAY_W'(5);
      MONTH_W'(5):  off = DAY_W'(7);
      MONTH_W'(6):  off = DAY_W'(10);
      MONTH_W'(7):  off = DAY_W'(12);
      MONTH_W'(8):  off = DAY_W'(15);
      MONTH_W'(9):  off = DAY_W'(18);
      MONTH_W'(10): off = DAY_W'(20);
      MONTH_W'(11): off = DAY_W'(23);
      MONTH_W'(12): off = DAY_W'(25);
      default:      off = '0;
    endcase
    return off;
  endfunction

  // 8 = 1 mod 7: fold octal digits twice, then one subtract
  function automatic logic [WDAY_W-1:0] mod7(logic [WSUM_W-1:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[WDAY_W-1:0];
  endfunction

endpackage

@@ sv/cdsem_item_if.sv @@
interface cdsem_item_if import cdsem_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [DAY_W-1:0]   load_day;
  logic [MONTH_W-1:0] load_month;
  logic [YEAR_W-1:0]  load_year;

  modport source (output valid, command, load_day, load_month, load_year, input ready);
  modport sink (input valid, command, load_day, load_month, load_year, output ready);
endinterface

@@ sv/cdsem_result_if.sv @@
interface cdsem_result_if import cdsem_pkg::*; #(
  parameter int NUM_EVENTS = NUM_EVENTS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [DAY_W-1:0]      day;
  logic [MONTH_W-1:0]    month;
  logic [YEAR_W-1:0]     year;
  logic [WDAY_W-1:0]     weekday;
  logic                  last_of_month;
  logic [NUM_EVENTS-1:0] event_hits;
  logic                  load_rejected;

  modport source (output valid, day, month, year, weekday, last_of_month, event_hits,
                  load_rejected, input ready);
  modport sink (input valid, day, month, year, weekday, last_of_month, event_hits,
                load_rejected, output ready);
endinterface

@@ sv/cdsem_cfg_if.sv @@
interface cdsem_cfg_if import cdsem_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PAT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/cdsem_date.sv @@
module cdsem_date import cdsem_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  cdsem_item_if.sink       item,
  output logic             rpt_valid,
  input  logic             rpt_ready,
  output date_rpt_t        rpt
);

  logic [DAY_W-1:0]   cur_day;
  logic [MONTH_W-1:0] cur_month;
  logic [YEAR_W-1:0]  cur_year;

  logic               cur_leap;
  logic [DAY_W-1:0]   cur_len;
  logic               ld_leap;
  logic [DAY_W-1:0]   ld_len;
  logic               ld_ok;
  logic               accept;

  assign item.ready = !rpt_valid || rpt_ready;
  assign accept     = item.valid && item.ready;

  assign cur_leap = is_leap(cur_year);
  assign cur_len  = month_len(cur_month, cur_leap);
  assign ld_leap  = is_leap(item.load_year);
  assign ld_len   = month_len(item.load_month, ld_leap);
  assign ld_ok    = (item.load_year >= YEAR_MIN) && (item.load_year <= YEAR_MAX) &&
                    (item.load_month >= MONTH_JAN) && (item.load_month <= MONTH_DEC) &&
                    (item.load_day >= DAY_FIRST) && (item.load_day <= ld_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day   <= DAY_FIRST;
      cur_month <= MONTH_JAN;
      cur_year  <= YEAR_MIN;
      rpt_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        rpt_valid <= accept;
      end
      if (accept) begin
        if (cmd_t'(item.command) == CMD_LOAD) begin
          if (ld_ok) begin
            cur_day      <= item.load_day;
            cur_month    <= item.load_month;
            cur_year     <= item.load_year;
            rpt.day      <= item.load_day;
            rpt.month    <= item.load_month;
            rpt.year     <= item.load_year;
            rpt.leap     <= ld_leap;
          end else begin
            rpt.day      <= cur_day;
            rpt.month    <= cur_month;
            rpt.year     <= cur_year;
            rpt.leap     <= cur_leap;
          end
          rpt.rejected <= !ld_ok;
        end else begin
          rpt.day      <= cur_day;
          rpt.month    <= cur_month;
          rpt.year     <= cur_year;
          rpt.leap     <= cur_leap;
          rpt.rejected <= 1'b0;
          // step one day; hold at the end of the range
          if (cur_day < cur_len) begin
            cur_day <= cur_day + DAY_W'(1);
          end else if (cur_month < MONTH_DEC) begin
            cur_day   <= DAY_FIRST;
            cur_month <= cur_month + MONTH_W'(1);
          end else if (cur_year < YEAR_MAX) begin
            cur_day   <= DAY_FIRST;
            cur_month <= MONTH_JAN;
            cur_year  <= cur_year + YEAR_W'(1);
          end
        end
      end
    end
  end

endmodule

@@ sv/cdsem_report.sv @@
module cdsem_report import cdsem_pkg::*; #(
  parameter int NUM_EVENTS = NUM_EVENTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rpt_valid,
  output logic             rpt_ready,
  input  date_rpt_t        rpt,
  cdsem_cfg_if.sink        cfg,
  cdsem_result_if.source   result
);

  logic [PAT_W-1:0] pattern [NUM_EVENTS];

  // weekday-sum stage
  logic               s2_valid;
  logic               s2_ready;
  logic [DAY_W-1:0]   s2_day;
  logic [MONTH_W-1:0] s2_month;
  logic [YEAR_W-1:0]  s2_year;
  logic               s2_last;
  logic               s2_rejected;
  logic [WSUM_W-1:0]  s2_wsum;

  logic [YEAR_W-1:0]     yy;
  logic [7:0]            q100;
  logic [WSUM_W-1:0]     wsum;
  logic [WDAY_W-1:0]     wd;
  logic [NUM_EVENTS-1:0] hits;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_EVENTS; i++) begin
        pattern[i] <= '0;
      end
    end else if (cfg.valid) begin
      // an index past the last pattern is dropped
      for (int i = 0; i < NUM_EVENTS; i++) begin
        if (cfg.index == CFG_IDX_W'(i)) begin
          pattern[i] <= cfg.data;
        end
      end
    end
  end

  // January and February count as months of the previous year
  assign yy   = (rpt.month < MONTH_MAR) ? rpt.year - YEAR_W'(1) : rpt.year;
  assign q100 = div100(yy);
  assign wsum = WSUM_W'(rpt.day) + WSUM_W'(yy) + WSUM_W'(yy[YEAR_W-1:2]) - WSUM_W'(q100)
              + WSUM_W'(q100[7:2]) + WSUM_W'(month_offset(rpt.month));

  assign s2_ready  = !result.valid || result.ready;
  assign rpt_ready = !s2_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      if (rpt_ready) begin
        s2_valid <= rpt_valid;
      end
    end
    if (rpt_ready && rpt_valid) begin
      s2_day      <= rpt.day;
      s2_month    <= rpt.month;
      s2_year     <= rpt.year;
      s2_last     <= (rpt.day == month_len(rpt.month, rpt.leap));
      s2_rejected <= rpt.rejected;
      s2_wsum     <= wsum;
    end
  end

  assign wd = mod7(s2_wsum);

  always_comb begin
    logic [5:0]         pd;
    logic [MONTH_W-1:0] pm;
    logic [YEAR_W-1:0]  py;
    logic [WDAY_W-1:0]  pw;
    logic               dok;
    logic               mok;
    logic               yok;
    logic               wok;
    hits = '0;
    for (int i = 0; i < NUM_EVENTS; i++) begin
      pd  = pattern[i][6:1];
      pm  = pattern[i][10:7];
      py  = pattern[i][24:11];
      pw  = pattern[i][27:25];
      dok = (pd == '0) || (pd == 6'(s2_day)) || ((pd == PAT_DAY_LAST) && s2_last);
      mok = (pm == '0) || (pm == s2_month);
      yok = (py == '0) || (py == s2_year);
      wok = (pw == '0) || (pw == wd + WDAY_W'(1));
      hits[i] = pattern[i][0] && dok && mok && yok && wok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else begin
      if (s2_ready) begin
        result.valid <= s2_valid;
      end
    end
    if (s2_ready && s2_valid) begin
      result.day           <= s2_day;
      result.month         <= s2_month;
      result.year          <= s2_year;
      result.weekday       <= wd;
      result.last_of_month <= s2_last;
      result.event_hits    <= hits;
      result.load_rejected <= s2_rejected;
    end
  end

endmodule

@@ sv/calendar_day_stepper_with_event_match.sv @@
// Holds a Gregorian date in the range 1.1.1754 to 31.12.9999, reset to 1.1.1754.
// A load transaction replaces the date when it is valid and otherwise keeps it and
// sets load_rejected; its result reports the date held afterwards. An advance
// transaction reports the held date and then steps it one day, holding at
// 31.12.9999. Each result carries the weekday (0 is Sunday), a last-day-of-month
// flag and one hit bit per event pattern, set for an enabled pattern that matches.
// The block takes one transaction per clock cycle unless the result side stalls;
// a result passes from the date report register, loaded on acceptance, through the
// weekday sum register to the result register, each stage moving on as soon as the
// next has room. Pattern registers are written through the configuration channel,
// which is always ready; indexes at or above NUM_EVENTS are ignored.
module calendar_day_stepper_with_event_match import cdsem_pkg::*; #(
  parameter int NUM_EVENTS = NUM_EVENTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  cdsem_item_if.sink       item,
  cdsem_result_if.source   result,
  cdsem_cfg_if.sink        cfg
);

  logic      rpt_valid;
  logic      rpt_ready;
  date_rpt_t rpt;

  cdsem_date u_date (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt)
  );

  cdsem_report #(
    .NUM_EVENTS (NUM_EVENTS)
  ) u_report (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt),
    .cfg       (cfg),
    .result    (result)
  );

endmodule
